/* rtl/ready_queue_cpu_scheduler_core_defines.svh */
// Assertion helpers for the ready queue scheduler.
`ifndef READY_QUEUE_CPU_SCHEDULER_CORE_DEFINES_SVH
`define READY_QUEUE_CPU_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RQCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rqcs assertion failed");

// Next-cycle implication, disabled while in reset.
`define RQCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rqcs assertion failed");

`endif

/* rtl/rqcs_pkg.sv */
`default_nettype none

package rqcs_pkg;

  // queue entry layout
  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  // shared comparator result
  typedef struct packed {
    logic        lt;
    logic        gt;
    logic [15:0] diff;
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_CALC,
    S_DONE
  } state_t;

  // selection policies
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  // item modes
  localparam logic MODE_ENQ  = 1'b0;
  localparam logic MODE_DISP = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_ENQ     = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_DONE    = 3'd2;
  localparam logic [2:0] STAT_REQUEUE = 3'd3;
  localparam logic [2:0] STAT_EMPTY   = 3'd4;

  // register indexes (paddr[2])
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  localparam logic [15:0] QUANTUM_RST = 16'd10;

endpackage

`default_nettype wire

/* rtl/rqcs_if.sv */
`default_nettype none

interface rqcs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  process_tag;
  logic [7:0]  priority_req;
  logic [15:0] burst_length;

  modport source (output valid, mode, process_tag, priority_req, burst_length,
                  input ready);
  modport sink   (input valid, mode, process_tag, priority_req, burst_length,
                  output ready);
endinterface

interface rqcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  chosen_tag;
  logic [7:0]  chosen_priority;
  logic [15:0] run_time;
  logic [31:0] busy_total;

  modport source (output valid, status, chosen_tag, chosen_priority, run_time,
                  busy_total, input ready);
  modport sink   (input valid, status, chosen_tag, chosen_priority, run_time,
                  busy_total, output ready);
endinterface

`default_nettype wire

/* rtl/ready_queue_cpu_scheduler_core.sv */
// Channel  | Dir | Handshake          | Beat payload
// ---------+-----+--------------------+-------------------------------------------------
// in_bus   | in  | valid/ready        | mode, process_tag, priority_req, burst_length
// out_bus  | out | valid/ready        | status, chosen_tag, chosen_priority, run_time,
//          |     |                    | busy_total
// APB      | in  | psel/penable/pready| paddr, pwdata, prdata (policy @0, quantum @4)
//
// Enqueue, full, empty: accept leads to the done state, which loads the result into
// the output register; no new beat is taken until then. Dispatch of N entries at
// position P (0 = head): accept, scan (all N for shortest burst and priority, else head
// only), shift behind P, calc, result, serialized by one read port and one comparator.
// Sync reset: queue empty, busy total 0, policy FIFO, quantum 10; no clearing pass.
// A result waits in the output register while the next beat runs; a second one stalls.
`default_nettype none
`include "ready_queue_cpu_scheduler_core_defines.svh"

module ready_queue_cpu_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rqcs_in_if.sink          in_bus,
  rqcs_out_if.source       out_bus,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);  // holds the count itself
  localparam int AW = $clog2(QUEUE_DEPTH);      // memory address

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  rqcs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]    count_r;
  logic [31:0]      busy_r;
  logic [1:0]       policy_r;
  logic [15:0]      quantum_r;

  logic [CW-1:0]    rd_idx_r;    // next address to read
  logic             rv_r;        // rd_data_r holds a requested entry
  logic [CW-1:0]    rv_idx_r;    // its position
  rqcs_pkg::entry_t rd_data_r;

  logic [CW-1:0]    best_pos_r;
  rqcs_pkg::entry_t best_r;      // selected entry (zero for non-dispatch results)
  logic [2:0]       status_r;
  logic [15:0]      run_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [7:0]       out_tag_r;
  logic [7:0]       out_prio_r;
  logic [15:0]      out_run_r;
  logic [31:0]      out_busy_r;

  // queue storage, undefined until written
  rqcs_pkg::entry_t mem [QUEUE_DEPTH];

  // ---------------------------------------------------------------------------
  // Combinational control
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             full;
  logic [CW-1:0]    scan_lim;
  logic             scan_last;
  logic             take;
  logic             issue;
  logic             requeue;
  logic             out_load;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rqcs_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  logic [15:0]      cmp_a, cmp_b;
  rqcs_pkg::cmp_res_t cmp_res;
  logic [32:0]      busy_sum;
  logic [31:0]      busy_sat;
  logic             cfg_wr;

  assign accept   = in_bus.valid && in_bus.ready;
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign scan_lim = (policy_r == rqcs_pkg::POL_SJF || policy_r == rqcs_pkg::POL_PRIO)
                    ? count_r : CW'(1);
  assign requeue  = (policy_r == rqcs_pkg::POL_RR) && cmp_res.gt;
  assign busy_sum = {1'b0, busy_r} + {17'd0, run_r};
  assign busy_sat = busy_sum[32] ? 32'hFFFF_FFFF : busy_sum[31:0];

  rqcs_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rqcs_pkg::S_IDLE: begin
        if (accept) begin
          if (in_bus.mode == rqcs_pkg::MODE_DISP && count_r != CW'(0)) begin
            state_nxt = rqcs_pkg::S_SCAN;
          end else begin
            state_nxt = rqcs_pkg::S_DONE;
          end
        end
      end
      rqcs_pkg::S_SCAN: begin
        if (scan_last) state_nxt = rqcs_pkg::S_SHIFT;
      end
      rqcs_pkg::S_SHIFT: begin
        if (!issue && !rv_r) state_nxt = rqcs_pkg::S_CALC;
      end
      rqcs_pkg::S_CALC: state_nxt = rqcs_pkg::S_DONE;
      rqcs_pkg::S_DONE: begin
        if (out_load) state_nxt = rqcs_pkg::S_IDLE;
      end
      default: state_nxt = rqcs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_bus.ready = 1'b0;
    issue        = 1'b0;
    take         = 1'b0;
    scan_last    = 1'b0;
    out_load     = 1'b0;
    rd_addr      = rd_idx_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = '{tag: in_bus.process_tag, prio: in_bus.priority_req,
                     burst: in_bus.burst_length};
    cmp_a        = 16'd0;
    cmp_b        = 16'd0;
    unique case (state_r)
      rqcs_pkg::S_IDLE: begin
        in_bus.ready = 1'b1;
        wr_en        = accept && (in_bus.mode == rqcs_pkg::MODE_ENQ) && !full;
      end
      rqcs_pkg::S_SCAN: begin
        issue = (rd_idx_r < scan_lim);
        if (policy_r == rqcs_pkg::POL_PRIO) begin
          cmp_a = {8'd0, rd_data_r.prio};
          cmp_b = {8'd0, best_r.prio};
          take  = rv_r && (rv_idx_r == CW'(0) || cmp_res.gt);
        end else begin
          cmp_a = rd_data_r.burst;
          cmp_b = best_r.burst;
          take  = rv_r && (rv_idx_r == CW'(0) || cmp_res.lt);
        end
        scan_last = rv_r && (rv_idx_r == CW'(scan_lim - CW'(1)));
      end
      rqcs_pkg::S_SHIFT: begin
        issue   = (rd_idx_r < count_r);
        wr_en   = rv_r;
        wr_addr = AW'(rv_idx_r - CW'(1));
        wr_data = rd_data_r;
      end
      rqcs_pkg::S_CALC: begin
        cmp_a   = best_r.burst;
        cmp_b   = quantum_r;
        wr_en   = requeue;
        wr_addr = AW'(count_r - CW'(1));
        wr_data = '{tag: best_r.tag, prio: best_r.prio, burst: cmp_res.diff};
      end
      rqcs_pkg::S_DONE: begin
        out_load = !out_valid_r || out_bus.ready;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory: one write, one registered read per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rqcs_pkg::S_IDLE;
      count_r     <= '0;
      busy_r      <= '0;
      policy_r    <= rqcs_pkg::POL_FIFO;
      quantum_r   <= rqcs_pkg::QUANTUM_RST;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == rqcs_pkg::REG_QUANTUM) quantum_r <= pwdata[15:0];
        else                                    policy_r  <= pwdata[1:0];
      end
      rv_r <= issue;
      if (state_r == rqcs_pkg::S_IDLE && wr_en) count_r <= count_r + CW'(1);
      if (state_r == rqcs_pkg::S_CALC && !requeue) count_r <= count_r - CW'(1);
      if (out_load) begin
        busy_r      <= busy_sat;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rv_idx_r <= rd_idx_r;
    if (issue) rd_idx_r <= rd_idx_r + CW'(1);
    if (take) begin
      best_r     <= rd_data_r;
      best_pos_r <= rv_idx_r;
    end
    // shift starts just past the chosen entry
    if (scan_last) rd_idx_r <= (take ? rv_idx_r : best_pos_r) + CW'(1);
    if (accept) begin
      rd_idx_r <= '0;
      best_r   <= '0;
      run_r    <= 16'd0;
      if (in_bus.mode == rqcs_pkg::MODE_ENQ) begin
        status_r <= full ? rqcs_pkg::STAT_FULL : rqcs_pkg::STAT_ENQ;
      end else begin
        status_r <= rqcs_pkg::STAT_EMPTY;
      end
    end
    if (state_r == rqcs_pkg::S_CALC) begin
      run_r    <= requeue ? quantum_r : best_r.burst;
      status_r <= requeue ? rqcs_pkg::STAT_REQUEUE : rqcs_pkg::STAT_DONE;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_tag_r    <= best_r.tag;
      out_prio_r   <= best_r.prio;
      out_run_r    <= run_r;
      out_busy_r   <= busy_sat;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = out_status_r;
  assign out_bus.chosen_tag      = out_tag_r;
  assign out_bus.chosen_priority = out_prio_r;
  assign out_bus.run_time        = out_run_r;
  assign out_bus.busy_total      = out_busy_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rqcs_pkg::REG_QUANTUM) ? {16'd0, quantum_r}
                                                      : {30'd0, policy_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RQCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_bus.ready)
  `RQCS_ASSERT_NEXT(a_enq_grows, clk, rst_n,
    accept && in_bus.mode == rqcs_pkg::MODE_ENQ && !full,
    count_r == $past(count_r) + CW'(1))
  `RQCS_ASSERT_NEXT(a_busy_monotonic, clk, rst_n, 1'b1, busy_r >= $past(busy_r))
  `RQCS_ASSERT_IMPL(a_count_bound, clk, rst_n,
    state_r == rqcs_pkg::S_IDLE, count_r <= CW'(QUEUE_DEPTH))

endmodule

`default_nettype wire

/* rtl/rqcs_cmp.sv */
`default_nettype none

// Shared 16-bit compare/subtract unit.
module rqcs_cmp (
  input  wire logic [15:0]      a,
  input  wire logic [15:0]      b,
  output rqcs_pkg::cmp_res_t    res
);

  logic [16:0] sub;

  assign sub      = {1'b0, a} - {1'b0, b};
  assign res.lt   = sub[16];
  assign res.gt   = !sub[16] && (sub[15:0] != 16'd0);
  assign res.diff = sub[15:0];

endmodule

`default_nettype wire

/* verif/tb_ready_queue_cpu_scheduler_core.sv */
module tb_ready_queue_cpu_scheduler_core;
  import rqcs_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  // Slowest gap between beats is a full-queue dispatch plus the longest sender
  // gap and receiver stall; this is many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 11;
  localparam int PHASE_BEATS    = 100;
  localparam int PLAN_ROWS      = 33;

  // one input beat
  typedef struct packed {
    logic        mode;
    logic [7:0]  tag;
    logic [7:0]  prio;
    logic [15:0] burst;
  } sched_beat_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tag;
    logic [7:0]  prio;
    logic [15:0] run;
    logic [31:0] busy;
  } dispatch_result_t;

  // directed row: either a register write or a beat, optionally with the
  // result written out by hand
  typedef struct packed {
    logic             is_reg;
    logic             reg_idx;
    logic [31:0]      reg_val;
    sched_beat_t      beat;
    logic             typed;
    dispatch_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rqcs_in_if  in_bus ();
  rqcs_out_if out_bus ();

  ready_queue_cpu_scheduler_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler mirror: queue in arrival order, busy total, both registers.
  // ---------------------------------------------------------------------------
  entry_t      rq_slot [QUEUE_DEPTH];
  int unsigned rq_fill;
  logic [31:0] busy_ms;
  logic [1:0]  sched_policy;
  logic [15:0] slice_ms;

  dispatch_result_t awaited_q [$];
  int fault_cnt;
  int beats_in;
  int status_tally [5];

  // Sender/receiver idling state
  logic       idle_on;
  int         burst_left;
  logic [7:0] stall_mask;
  logic [2:0] stall_pos;
  int         mask_life;
  int         quiet_cycles;

  function automatic dispatch_result_t schedule_next(input sched_beat_t b);
    dispatch_result_t r;
    entry_t           picked;
    int unsigned      pos;
    int unsigned      i;
    logic [32:0]      sum;
    r = '0;
    if (b.mode == MODE_ENQ) begin
      if (rq_fill >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;                // dropped, queue untouched
      end else begin
        picked.tag   = b.tag;
        picked.prio  = b.prio;
        picked.burst = b.burst;
        rq_slot[rq_fill] = picked;
        rq_fill++;
        r.status = STAT_ENQ;
      end
    end else if (rq_fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      // strict compares keep ties on the entry nearest the head
      pos = 0;
      for (i = 1; i < rq_fill; i++) begin
        if (sched_policy == POL_SJF && rq_slot[i].burst < rq_slot[pos].burst) pos = i;
        if (sched_policy == POL_PRIO && rq_slot[i].prio > rq_slot[pos].prio) pos = i;
      end
      picked = rq_slot[pos];
      for (i = pos; i + 1 < rq_fill; i++) rq_slot[i] = rq_slot[i + 1];
      rq_fill--;
      r.tag  = picked.tag;
      r.prio = picked.prio;
      if (sched_policy == POL_RR && picked.burst > slice_ms) begin
        // slice used up: back to the tail with what is left
        r.run        = slice_ms;
        r.status     = STAT_REQUEUE;
        picked.burst = picked.burst - slice_ms;
        rq_slot[rq_fill] = picked;
        rq_fill++;
      end else begin
        r.run    = picked.burst;
        r.status = STAT_DONE;
      end
      sum     = {1'b0, busy_ms} + {17'd0, r.run};
      busy_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    r.busy = busy_ms;
    return r;
  endfunction

  function automatic logic [15:0] pick_burst(input logic [15:0] q);
    logic [15:0] v;
    case ($urandom_range(6, 0))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = q;                        // exactly one slice
      3:       v = q + 16'd1;                // one over the slice
      4, 5:    v = 16'($urandom_range(40, 0));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // directed-table row builders
  function automatic plan_row_t cfg_row(input logic idx, input logic [31:0] v);
    plan_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    return row;
  endfunction

  function automatic plan_row_t beat_row(input logic m, input logic [7:0] t,
                                         input logic [7:0] p, input logic [15:0] bl);
    plan_row_t row;
    row            = '0;
    row.beat.mode  = m;
    row.beat.tag   = t;
    row.beat.prio  = p;
    row.beat.burst = bl;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic m, input logic [7:0] t,
                                          input logic [7:0] p, input logic [15:0] bl,
                                          input logic [2:0] st, input logic [7:0] ct,
                                          input logic [7:0] cp, input logic [15:0] rt,
                                          input logic [31:0] bt);
    plan_row_t row;
    row             = beat_row(m, t, p, bl);
    row.typed       = 1'b1;
    row.want.status = st;
    row.want.tag    = ct;
    row.want.prio   = cp;
    row.want.run    = rt;
    row.want.busy   = bt;
    return row;
  endfunction

  plan_row_t opening_plan [PLAN_ROWS] = '{
    // after reset: empty queue, FIFO, quantum 10
    typed_row(MODE_DISP, 8'h00, 8'h00, 16'h0000, STAT_EMPTY, 8'h00, 8'h00, 16'h0000, 32'h0),
    typed_row(MODE_ENQ,  8'hFF, 8'hFF, 16'hFFFF, STAT_ENQ,   8'h00, 8'h00, 16'h0000, 32'h0),
    typed_row(MODE_ENQ,  8'h00, 8'h00, 16'h0000, STAT_ENQ,   8'h00, 8'h00, 16'h0000, 32'h0),
    typed_row(MODE_DISP, 8'h00, 8'h00, 16'h0000, STAT_DONE,  8'hFF, 8'hFF, 16'hFFFF,
              32'h0000_FFFF),
    // zero burst, ignored fields all ones
    typed_row(MODE_DISP, 8'hFF, 8'hFF, 16'hFFFF, STAT_DONE,  8'h00, 8'h00, 16'h0000,
              32'h0000_FFFF),
    typed_row(MODE_DISP, 8'hA5, 8'h5A, 16'h1234, STAT_EMPTY, 8'h00, 8'h00, 16'h0000,
              32'h0000_FFFF),
    // shortest burst, with a tie behind the winner
    cfg_row(REG_POLICY, 32'(POL_SJF)),
    beat_row(MODE_ENQ,  8'h11, 8'd10, 16'd300),
    beat_row(MODE_ENQ,  8'h12, 8'd20, 16'd100),
    beat_row(MODE_ENQ,  8'h13, 8'd30, 16'd100),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    // highest priority, tie between 0x13 and 0x14
    cfg_row(REG_POLICY, 32'(POL_PRIO)),
    beat_row(MODE_ENQ,  8'h14, 8'd30, 16'd5),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    // round robin, zero quantum keeps the burst unchanged
    cfg_row(REG_POLICY, 32'(POL_RR)),
    cfg_row(REG_QUANTUM, 32'd0),
    beat_row(MODE_ENQ,  8'h21, 8'd40, 16'd25),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    cfg_row(REG_QUANTUM, 32'd10),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    // burst equal to the slice completes
    beat_row(MODE_ENQ,  8'h22, 8'd41, 16'd10),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    cfg_row(REG_QUANTUM, 32'h0000_FFFF),
    beat_row(MODE_ENQ,  8'h23, 8'd42, 16'hFFFF),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    cfg_row(REG_QUANTUM, 32'd1),
    beat_row(MODE_ENQ,  8'h24, 8'd43, 16'd2),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000),
    beat_row(MODE_DISP, 8'h00, 8'h00, 16'h0000)
  };

  logic [1:0] phase_policy [PHASES] = '{
    POL_FIFO, POL_SJF, POL_PRIO, POL_RR, POL_RR, POL_SJF,
    POL_RR, POL_PRIO, POL_RR, POL_FIFO, POL_RR
  };

  // ---------------------------------------------------------------------------
  // Sender: offers one beat, predicts it once accepted. valid is left high on
  // return so back-to-back beats need no drop; drain_results lowers it.
  // ---------------------------------------------------------------------------
  task automatic push_beat(input sched_beat_t b, input logic typed,
                           input dispatch_result_t want);
    int               gap;
    dispatch_result_t r;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(24, 4) : $urandom_range(2, 0);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= b.mode;
    in_bus.process_tag  <= b.tag;
    in_bus.priority_req <= b.prio;
    in_bus.burst_length <= b.burst;
    do @(posedge clk); while (!in_bus.ready);
    r = schedule_next(b);
    status_tally[r.status]++;
    beats_in++;
    awaited_q.push_back(typed ? want : r);
  endtask

  // Stop offering beats and wait until every outstanding result is back.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; mirror updated on completion, then idle with psel
  // low so a following write starts on a fresh edge.
  task automatic reg_write(input logic idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POLICY) sched_policy = v[1:0];
    else                   slice_ms     = v[15:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: while idling is on, ready follows an 8-bit stall mask, redrawn when its life
  // count runs out. At least one ready slot per mask bounds every stall, also across a redraw.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] m;
    if (mask_life == 0) begin
      m = 8'($urandom);
      m[$urandom_range(7, 0)] = 1'b0;
      if ($urandom_range(3, 0) == 0) m = 8'h00;
      stall_mask <= m;
      mask_life  <= 63;
    end else begin
      mask_life <= mask_life - 1;
    end
    stall_pos     <= stall_pos + 3'd1;
    out_bus.ready <= !idle_on || !stall_mask[stall_pos];
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dispatch_result_t got;
    dispatch_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.tag    = out_bus.chosen_tag;
      got.prio   = out_bus.chosen_priority;
      got.run    = out_bus.run_time;
      got.busy   = out_bus.busy_total;
      if (awaited_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= REPORT_LIMIT)
          $display("result beat with nothing outstanding: status %0d tag %02h",
                   got.status, got.tag);
      end else begin
        exp_r = awaited_q.pop_front();
        if (got !== exp_r) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_LIMIT)
            $display({"result mismatch: exp st %0d tag %02h pri %02h run %04h busy %08h",
                      " | got st %0d tag %02h pri %02h run %04h busy %08h"},
                     exp_r.status, exp_r.tag, exp_r.prio, exp_r.run, exp_r.busy,
                     got.status, got.tag, got.prio, got.run, got.busy);
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel and no register write.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, awaited_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          n;
    int          enq_pct;
    sched_beat_t b;
    logic [15:0] q;

    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.mode         = MODE_ENQ;
    in_bus.process_tag  = '0;
    in_bus.priority_req = '0;
    in_bus.burst_length = '0;
    out_bus.ready       = 1'b0;
    stall_mask          = '0;
    stall_pos           = '0;
    mask_life           = 0;
    quiet_cycles        = 0;
    idle_on             = 1'b1;
    burst_left          = 0;
    fault_cnt           = 0;
    beats_in            = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    rq_fill             = 0;
    busy_ms             = '0;
    sched_policy        = POL_FIFO;
    slice_ms            = QUANTUM_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; register rows wait for the block to go idle first.
    foreach (opening_plan[i]) begin
      if (opening_plan[i].is_reg) begin
        drain_results();
        reg_write(opening_plan[i].reg_idx, opening_plan[i].reg_val);
      end else begin
        push_beat(opening_plan[i].beat, opening_plan[i].typed, opening_plan[i].want);
      end
    end

    // Random phases: every policy, quantum extremes, varying enqueue mix so the
    // queue swings between empty and full.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      idle_on    = (ph % 3) != 2;
      burst_left = 0;
      case (ph)
        3:       q = 16'd0;
        4:       q = 16'd1;
        6:       q = 16'hFFFF;
        8:       q = 16'($urandom_range(40, 2));
        default: q = 16'($urandom);
      endcase
      reg_write(REG_POLICY, 32'(phase_policy[ph]));
      reg_write(REG_QUANTUM, 32'(q));
      enq_pct = $urandom_range(75, 35);
      for (n = 0; n < PHASE_BEATS; n++) begin
        b.mode = ($urandom_range(99, 0) < enq_pct) ? MODE_ENQ : MODE_DISP;
        b.tag  = 8'($urandom);
        if ($urandom_range(1, 0) == 0) b.prio = 8'($urandom_range(3, 0));
        else                           b.prio = 8'($urandom);
        b.burst = pick_burst(q);
        push_beat(b, 1'b0, '0);
      end
    end

    drain_results();
    // room for any stray result after the last expected one
    repeat (64) @(posedge clk);

    $display("covered %0d beats: %0d enqueued, %0d refused full, %0d ran out, %0d requeued,",
             beats_in, status_tally[STAT_ENQ], status_tally[STAT_FULL],
             status_tally[STAT_DONE], status_tally[STAT_REQUEUE]);
    $display("%0d dispatches on an empty queue; all four policies; final busy total %08h",
             status_tally[STAT_EMPTY], busy_ms);
    if (fault_cnt == 0 && awaited_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
